// ----- rtl/core/line_3d_point_stepper_macros.svh -----
// Assertion macros shared by the line stepper RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LINE_3D_POINT_STEPPER_MACROS_SVH
`define LINE_3D_POINT_STEPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define L3PS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line stepper check failed");

// Next-cycle implication, disabled while reset is low.
`define L3PS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line stepper check failed");

`endif

// ----- rtl/core/l3ps_pkg.sv -----
// Shared types, opcodes and axis helpers for the 3D line stepper.
// No dependencies.
package l3ps_pkg;

    // Opcode of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Driving axis code
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // First minor axis: X drives -> Y, Y drives -> X, Z drives -> Y
    function automatic logic [1:0] minor_a(t_axis d);
        logic [1:0] r;
        unique case (d)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_X;
            AXIS_Z:  r = AXIS_Y;
            default: r = AXIS_Y;
        endcase
        return r;
    endfunction

    // Second minor axis: X drives -> Z, Y drives -> Z, Z drives -> X
    function automatic logic [1:0] minor_b(t_axis d);
        logic [1:0] r;
        unique case (d)
            AXIS_X:  r = AXIS_Z;
            AXIS_Y:  r = AXIS_Z;
            AXIS_Z:  r = AXIS_X;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

    // Array index of the driving axis, an unused code maps to Z
    function automatic logic [1:0] axis_idx(t_axis d);
        logic [1:0] r;
        unique case (d)
            AXIS_X:  r = AXIS_X;
            AXIS_Y:  r = AXIS_Y;
            AXIS_Z:  r = AXIS_Z;
            default: r = AXIS_Z;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/l3ps_if.sv -----
// Valid/ready channel interfaces for the line stepper: command in, point out.
// No dependencies.
interface l3ps_in_if #(
    parameter int COORD_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] start_z;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] end_z;

    modport source (
        output valid, opcode, start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

interface l3ps_out_if #(
    parameter int COORD_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [COORD_BITS-1:0] point_z;
    logic                  last;

    modport source (
        output valid, point_x, point_y, point_z, last,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, last,
        output ready
    );
endinterface

// ----- rtl/core/l3ps_setup.sv -----
// Line setup: absolute deltas, step signs, driving axis and initial error terms.
// Depends on l3ps_pkg.
module l3ps_setup #(
    parameter int  COORD_BITS = 8,
    localparam int ErrW       = COORD_BITS + 3
) (
    input  logic [2:0][COORD_BITS-1:0] i_start,
    input  logic [2:0][COORD_BITS-1:0] i_end,
    output logic [2:0][COORD_BITS-1:0] o_abs_delta,
    output logic [2:0]                 o_step_neg,
    output l3ps_pkg::t_axis            o_drive,
    output logic [1:0][ErrW-1:0]       o_err,
    output logic                       o_active
);

    logic [1:0]            d_idx;
    logic [1:0]            a_idx;
    logic [1:0]            b_idx;
    logic [ErrW-1:0]       dd_ext;

    // Per-axis magnitude and direction; step up only when end is above start
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_end[i] > i_start[i]) begin
                o_abs_delta[i] = i_end[i] - i_start[i];
                o_step_neg[i]  = 1'b0;
            end else begin
                o_abs_delta[i] = i_start[i] - i_end[i];
                o_step_neg[i]  = 1'b1;
            end
        end
    end

    // Pick driving axis: X on ties, then Y, else Z
    always_comb begin
        priority if (o_abs_delta[0] >= o_abs_delta[1] && o_abs_delta[0] >= o_abs_delta[2]) begin
            o_drive = l3ps_pkg::AXIS_X;
        end else if (o_abs_delta[1] >= o_abs_delta[2]) begin
            o_drive = l3ps_pkg::AXIS_Y;
        end else begin
            o_drive = l3ps_pkg::AXIS_Z;
        end
    end

    // Initial error terms: 2 * minor delta - driving delta
    assign d_idx  = l3ps_pkg::axis_idx(o_drive);
    assign a_idx  = l3ps_pkg::minor_a(o_drive);
    assign b_idx  = l3ps_pkg::minor_b(o_drive);
    assign dd_ext = {3'b000, o_abs_delta[d_idx]};

    assign o_err[0] = {2'b00, o_abs_delta[a_idx], 1'b0} - dd_ext;
    assign o_err[1] = {2'b00, o_abs_delta[b_idx], 1'b0} - dd_ext;

    // A line stays active unless start and end share the driving coordinate
    assign o_active = i_start[d_idx] != i_end[d_idx];

endmodule

// ----- rtl/core/line_3d_point_stepper.sv -----
// Path: an input transfer waits in the input register, and its point goes out from the result register.
// Throughput: one item per cycle while the output does not stall; the per-item step is one add/compare level
// between the input register and the result register, fed back through the line state.
// A step with no active line is consumed and returns nothing.
// Reset: synchronous, active low; clears both stage valids and all line state.
module line_3d_point_stepper #(
    parameter int COORD_BITS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    l3ps_in_if.sink  i_in,
    l3ps_out_if.source o_out
);

    `include "line_3d_point_stepper_macros.svh"

    localparam int ErrW = COORD_BITS + 3;

    // Input register
    logic                          r_in_vld;
    logic                          r_in_op;
    logic [2:0][COORD_BITS-1:0]    r_in_start;
    logic [2:0][COORD_BITS-1:0]    r_in_end;

    // Line state
    logic [2:0][COORD_BITS-1:0]    r_cur;
    logic [2:0][COORD_BITS-1:0]    r_end;
    logic [2:0][COORD_BITS-1:0]    r_abs;
    logic [2:0]                    r_neg;
    l3ps_pkg::t_axis               r_drive;
    logic [1:0][ErrW-1:0]          r_err;
    logic                          r_active;

    // Result register
    logic                          r_out_vld;
    logic [2:0][COORD_BITS-1:0]    r_pt;
    logic                          r_last;

    // Next values
    logic [2:0][COORD_BITS-1:0]    n_cur;
    logic [2:0][COORD_BITS-1:0]    n_end;
    logic [2:0][COORD_BITS-1:0]    n_abs;
    logic [2:0]                    n_neg;
    l3ps_pkg::t_axis               n_drive;
    logic [1:0][ErrW-1:0]          n_err;
    logic                          n_active;
    logic                          n_has_res;

    // Setup results for a load
    logic [2:0][COORD_BITS-1:0]    su_abs;
    logic [2:0]                    su_neg;
    l3ps_pkg::t_axis               su_drive;
    logic [1:0][ErrW-1:0]          su_err;
    logic                          su_active;

    // Step datapath
    logic [1:0]                    d_idx;
    logic [1:0]                    a_idx;
    logic [1:0]                    b_idx;
    logic [2:0][COORD_BITS-1:0]    mv_pos;
    logic [ErrW-1:0]               dd2;
    logic                          ge_a;
    logic                          ge_b;

    logic                          out_adv;
    logic                          fire;

    // Handshake: result stage advances when empty or drained
    assign out_adv    = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || out_adv;
    assign fire       = r_in_vld && out_adv;

    // Capture input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op    <= i_in.opcode;
            r_in_start <= {i_in.start_z, i_in.start_y, i_in.start_x};
            r_in_end   <= {i_in.end_z, i_in.end_y, i_in.end_x};
        end
    end

    l3ps_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start     (r_in_start),
        .i_end       (r_in_end),
        .o_abs_delta (su_abs),
        .o_step_neg  (su_neg),
        .o_drive     (su_drive),
        .o_err       (su_err),
        .o_active    (su_active)
    );

    // Step one unit along each axis in its own direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mv_pos[i] = r_neg[i] ? r_cur[i] - COORD_BITS'(1) : r_cur[i] + COORD_BITS'(1);
        end
    end

    assign d_idx = l3ps_pkg::axis_idx(r_drive);
    assign a_idx = l3ps_pkg::minor_a(r_drive);
    assign b_idx = l3ps_pkg::minor_b(r_drive);
    assign dd2   = {2'b00, r_abs[d_idx], 1'b0};
    assign ge_a  = !r_err[0][ErrW-1];
    assign ge_b  = !r_err[1][ErrW-1];

    // Next line state: load a new line, advance the active one, or hold
    always_comb begin
        n_cur     = r_cur;
        n_end     = r_end;
        n_abs     = r_abs;
        n_neg     = r_neg;
        n_drive   = r_drive;
        n_err     = r_err;
        n_active  = r_active;
        n_has_res = 1'b0;
        unique case (r_in_op)
            l3ps_pkg::OP_LOAD: begin
                n_cur     = r_in_start;
                n_end     = r_in_end;
                n_abs     = su_abs;
                n_neg     = su_neg;
                n_drive   = su_drive;
                n_err     = su_err;
                n_active  = su_active;
                n_has_res = 1'b1;
            end
            l3ps_pkg::OP_STEP: begin
                if (r_active) begin
                    n_cur[d_idx] = mv_pos[d_idx];
                    if (ge_a) begin
                        n_cur[a_idx] = mv_pos[a_idx];
                    end
                    if (ge_b) begin
                        n_cur[b_idx] = mv_pos[b_idx];
                    end
                    n_err[0]  = r_err[0] - (ge_a ? dd2 : '0)
                              + {2'b00, r_abs[a_idx], 1'b0};
                    n_err[1]  = r_err[1] - (ge_b ? dd2 : '0)
                              + {2'b00, r_abs[b_idx], 1'b0};
                    n_active  = n_cur[d_idx] != r_end[d_idx];
                    n_has_res = 1'b1;
                end
            end
            default: begin
                n_has_res = 1'b0;
            end
        endcase
    end

    // Hold line state, advance on each item that leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_end     <= '0;
            r_abs     <= '0;
            r_neg     <= '0;
            r_drive   <= l3ps_pkg::AXIS_X;
            r_err     <= '0;
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (fire) begin
                r_cur    <= n_cur;
                r_end    <= n_end;
                r_abs    <= n_abs;
                r_neg    <= n_neg;
                r_drive  <= n_drive;
                r_err    <= n_err;
                r_active <= n_active;
            end
            if (out_adv) begin
                r_out_vld <= fire && n_has_res;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fire && n_has_res) begin
            r_pt   <= n_cur;
            r_last <= !n_active;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.point_x = r_pt[0];
    assign o_out.point_y = r_pt[1];
    assign o_out.point_z = r_pt[2];
    assign o_out.last    = r_last;

    // A pending point flags last exactly when it closed the line
    `L3PS_ASSERT_IMPL(a_last_matches_active, i_clk, i_rst_n, r_out_vld, r_last == !r_active)
    // An active line never sits on its end coordinate
    `L3PS_ASSERT_IMPL(a_active_not_at_end, i_clk, i_rst_n, r_active, r_cur[d_idx] != r_end[d_idx])
    // Drop a step that finds no active line
    `L3PS_ASSERT_NEXT(a_idle_step_silent, i_clk, i_rst_n, fire && r_in_op == l3ps_pkg::OP_STEP && !r_active, !r_out_vld)

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the 3D Bresenham line stepper (line_3d_point_stepper).
// Depends on l3ps_pkg, the l3ps_in_if / l3ps_out_if channels and the stepper RTL.
// Each command transfer is predicted here, and every point out is checked in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 8;

    typedef logic [CB-1:0] t_coord;
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
    } t_point;

    localparam t_coord COORD_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #2 i_clk = ~i_clk;

    l3ps_in_if  #(.COORD_BITS(CB)) in_if ();
    l3ps_out_if #(.COORD_BITS(CB)) out_if ();

    line_3d_point_stepper #(.COORD_BITS(CB)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Line walker state, mirrored from the block
    t_coord          cur_pt  [3];
    t_coord          end_pt  [3];
    t_coord          span    [3];
    bit              dir_neg [3];
    l3ps_pkg::t_axis drive   = l3ps_pkg::AXIS_X;
    int              err_a   = 0;
    int              err_b   = 0;
    bit              line_on = 1'b0;

    t_point expected_points [$];
    int     fail_count     = 0;
    int     points_sent    = 0;
    bit     send_gaps_on   = 1'b1;
    bit     recv_stalls_on = 1'b1;
    bit     out_hold;
    int     hold_req       = 0;

    function automatic t_coord any_coord();
        return t_coord'($urandom_range(0, int'(COORD_MAX)));
    endfunction

    // Random coordinate within r of c, kept inside the field range
    function automatic t_coord near(t_coord c, int r);
        int lo;
        int hi;
        lo = int'(c) - r;
        hi = int'(c) + r;
        if (lo < 0) lo = 0;
        if (hi > int'(COORD_MAX)) hi = int'(COORD_MAX);
        return t_coord'($urandom_range(hi, lo));
    endfunction

    function automatic t_coord step_coord(int k);
        return dir_neg[k] ? t_coord'(cur_pt[k] - 1'b1) : t_coord'(cur_pt[k] + 1'b1);
    endfunction

    // Advance the mirrored walker by one command and queue the point it returns
    function automatic void predict_point(logic op, t_coord s[3], t_coord e[3]);
        int     d;
        int     a;
        int     b;
        t_point p;
        if (op == l3ps_pkg::OP_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                cur_pt[i] = s[i];
                end_pt[i] = e[i];
                if (e[i] > s[i]) begin
                    span[i]    = e[i] - s[i];
                    dir_neg[i] = 1'b0;
                end else begin
                    span[i]    = s[i] - e[i];
                    dir_neg[i] = 1'b1;
                end
            end
            // X wins ties, then Y over Z
            if (span[l3ps_pkg::AXIS_X] >= span[l3ps_pkg::AXIS_Y] &&
                span[l3ps_pkg::AXIS_X] >= span[l3ps_pkg::AXIS_Z])
                drive = l3ps_pkg::AXIS_X;
            else if (span[l3ps_pkg::AXIS_Y] >= span[l3ps_pkg::AXIS_Z])
                drive = l3ps_pkg::AXIS_Y;
            else
                drive = l3ps_pkg::AXIS_Z;
        end else if (!line_on) begin
            return;
        end

        d = int'(drive);
        case (drive)
            l3ps_pkg::AXIS_X: begin
                a = l3ps_pkg::AXIS_Y;
                b = l3ps_pkg::AXIS_Z;
            end
            l3ps_pkg::AXIS_Y: begin
                a = l3ps_pkg::AXIS_X;
                b = l3ps_pkg::AXIS_Z;
            end
            default: begin
                a = l3ps_pkg::AXIS_Y;
                b = l3ps_pkg::AXIS_X;
            end
        endcase

        if (op == l3ps_pkg::OP_LOAD) begin
            err_a = 2 * int'(span[a]) - int'(span[d]);
            err_b = 2 * int'(span[b]) - int'(span[d]);
        end else begin
            cur_pt[d] = step_coord(d);
            if (err_a >= 0) begin
                cur_pt[a] = step_coord(a);
                err_a -= 2 * int'(span[d]);
            end
            if (err_b >= 0) begin
                cur_pt[b] = step_coord(b);
                err_b -= 2 * int'(span[d]);
            end
            err_a += 2 * int'(span[a]);
            err_b += 2 * int'(span[b]);
        end

        line_on = cur_pt[d] != end_pt[d];
        p.x     = cur_pt[l3ps_pkg::AXIS_X];
        p.y     = cur_pt[l3ps_pkg::AXIS_Y];
        p.z     = cur_pt[l3ps_pkg::AXIS_Z];
        p.last  = !line_on;
        expected_points = {expected_points, p};
        points_sent++;
    endfunction

    // Offer one command, hold it until the transfer, then predict its point
    task automatic send_cmd(input logic op, input t_coord sx, input t_coord sy,
                            input t_coord sz, input t_coord ex, input t_coord ey,
                            input t_coord ez);
        t_coord s[3];
        t_coord e[3];
        s = '{sx, sy, sz};
        e = '{ex, ey, ez};
        if (send_gaps_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.opcode  <= op;
        in_if.start_x <= sx;
        in_if.start_y <= sy;
        in_if.start_z <= sz;
        in_if.end_x   <= ex;
        in_if.end_y   <= ey;
        in_if.end_z   <= ez;
        do @(posedge i_clk); while (!in_if.ready);
        predict_point(op, s, e);
    endtask

    task automatic send_load(input t_coord sx, input t_coord sy, input t_coord sz,
                             input t_coord ex, input t_coord ey, input t_coord ez);
        send_cmd(l3ps_pkg::OP_LOAD, sx, sy, sz, ex, ey, ez);
    endtask

    // Step fields are don't-care; randomize them anyway
    task automatic send_step();
        send_cmd(l3ps_pkg::OP_STEP, any_coord(), any_coord(), any_coord(),
                 any_coord(), any_coord(), any_coord());
    endtask

    task automatic walk_line();
        while (line_on) send_step();
    endtask

    // Steps with no line loaded must return nothing
    task automatic test_idle_steps();
        send_step();
        send_step();
    endtask

    // Zero-length lines, tie-breaking, every driving axis, both directions, reload
    task automatic test_directed_lines();
        send_load(0, 0, 0, 0, 0, 0);
        send_step();
        send_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_load(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_step();
        send_step();
        send_load(COORD_MAX, 0, COORD_MAX, COORD_MAX - t_coord'(5), 3,
                  COORD_MAX - t_coord'(4));
        walk_line();
        send_step();
        send_load(10, 20, 30, 12, 24, 27);
        walk_line();
        send_load(3, 3, 9, 4, 1, 5);
        walk_line();
        send_load(0, 0, 0, 1, 2, 2);
        walk_line();
    endtask

    // One full-span line walked to its end point
    task automatic test_long_line();
        send_load(0, COORD_MAX, any_coord(), COORD_MAX, 0, any_coord());
        walk_line();
    endtask

    // Hold the output off for a long stretch while commands keep coming
    task automatic test_backpressure();
        send_gaps_on = 1'b0;
        hold_req    <= 200;
        send_load(10, 10, 10, 60, 40, 20);
        walk_line();
        send_gaps_on = 1'b1;
    endtask

    // Mostly short well-formed lines, some long partial lines, reloads and noise
    task automatic test_random_lines(input int n_points);
        int     goal;
        int     kind;
        int     n;
        t_coord s[3];
        goal = points_sent + n_points;
        while (points_sent < goal) begin
            kind = $urandom_range(0, 19);
            for (int i = 0; i < 3; i++) s[i] = any_coord();
            if (kind < 14) begin
                send_load(s[0], s[1], s[2], near(s[0], 12), near(s[1], 12), near(s[2], 12));
                walk_line();
                if ($urandom_range(0, 3) == 0) send_step();
            end else if (kind < 17) begin
                send_load(s[0], s[1], s[2], any_coord(), any_coord(), any_coord());
                n = $urandom_range(0, 20);
                while (line_on && n > 0) begin
                    send_step();
                    n--;
                end
            end else if (kind < 19) begin
                send_cmd(logic'($urandom_range(0, 1)), any_coord(), any_coord(),
                         any_coord(), any_coord(), any_coord(), any_coord());
            end else begin
                send_load(s[0], s[1], s[2], s[0], s[1], s[2]);
            end
        end
    endtask

    // Compare one output transfer against the oldest queued point
    task automatic check_point();
        t_point want;
        if (expected_points.size() == 0) begin
            $error("unexpected point x=%0d y=%0d z=%0d last=%0b",
                   out_if.point_x, out_if.point_y, out_if.point_z, out_if.last);
            fail_count++;
        end else begin
            want = expected_points.pop_front();
            if (out_if.point_x !== want.x) begin
                $error("point_x: expected %0d, got %0d", want.x, out_if.point_x);
                fail_count++;
            end
            if (out_if.point_y !== want.y) begin
                $error("point_y: expected %0d, got %0d", want.y, out_if.point_y);
                fail_count++;
            end
            if (out_if.point_z !== want.z) begin
                $error("point_z: expected %0d, got %0d", want.z, out_if.point_z);
                fail_count++;
            end
            if (out_if.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, out_if.last);
                fail_count++;
            end
        end
    endtask

    // Output side: check each transfer, stall ready in random bursts
    initial begin : point_sink
        int stall_left;
        stall_left    = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) check_point();
            if (stall_left > 0)
                stall_left--;
            else if (recv_stalls_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
            out_if.ready <= !out_hold && stall_left == 0;
        end
    end

    // Long output hold, counted here once requested
    initial begin : hold_counter
        int n;
        out_hold <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                n         = hold_req;
                hold_req <= 0;
                out_hold <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_hold <= 1'b0;
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main_seq
        int waited;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.opcode  <= l3ps_pkg::OP_LOAD;
        in_if.start_x <= '0;
        in_if.start_y <= '0;
        in_if.start_z <= '0;
        in_if.end_x   <= '0;
        in_if.end_y   <= '0;
        in_if.end_z   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_steps();
        test_directed_lines();
        test_long_line();
        test_backpressure();
        test_random_lines(250);
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        test_random_lines(100);
        in_if.valid <= 1'b0;

        // Drain: wait for the outstanding points, then keep clocking before the final check
        waited = 0;
        while (expected_points.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            $error("%0d expected points never arrived", expected_points.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
